### sv/bdq_pkg.sv
// shared types and codes for the bounded deque with search
package bdq_pkg;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  localparam logic [OPCODE_W-1:0] OP_ADD_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REM_FRONT = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REM_BACK  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CONTAINS  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_GET       = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_REVERSE   = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic latch;
    logic exec;
    logic rd_capture;
    logic scan_step;
    logic load_out;
  } bdq_cmd_t;

  typedef struct packed {
    logic need_read;
    logic need_scan;
    logic scan_done;
  } bdq_stat_t;

endpackage

### sv/bdq_if.sv
// valid/ready channel interfaces for operation requests and results
interface bdq_in_if;
  import bdq_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [VALUE_W-1:0]  value;
  logic [POS_W-1:0]           position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface bdq_out_if;
  import bdq_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic                       found;
  logic signed [VALUE_W-1:0]  read_value;
  logic [COUNT_W-1:0]         element_count;

  modport source (output valid, output status, output found, output read_value,
                  output element_count, input ready);
  modport sink   (input valid, input status, input found, input read_value,
                  input element_count, output ready);
endinterface

### sv/bdq_ram.sv
// generic single write port ram with registered read
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/bdq_ctrl.sv
// controller state machine: sequences accept, execute, read, scan and result hand-off
module bdq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bdq_pkg::bdq_stat_t stat,
  output bdq_pkg::bdq_cmd_t  cmd
);
  import bdq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RDW  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.need_read) begin
          state_nxt = S_RDW;
        end else if (stat.need_scan) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RDW: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_FIN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/bdq_dp.sv
// datapath: ring pointers, count, direction flag, element ram, scan and result registers
module bdq_dp #(
  parameter int CAPACITY      = 256,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [bdq_pkg::OPCODE_W-1:0]         in_opcode,
  input  logic signed [bdq_pkg::VALUE_W-1:0]   in_value,
  input  logic [bdq_pkg::POS_W-1:0]            in_position,
  input  bdq_pkg::bdq_cmd_t                    cmd,
  output bdq_pkg::bdq_stat_t                   stat,
  output logic [bdq_pkg::STATUS_W-1:0]         out_status,
  output logic                                 out_found,
  output logic signed [bdq_pkg::VALUE_W-1:0]   out_read_value,
  output logic [bdq_pkg::COUNT_W-1:0]          out_element_count
);
  import bdq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int EW = ELEMENT_WIDTH;

  // latched transaction
  logic [OPCODE_W-1:0] op_r;
  logic [VALUE_W-1:0]  value_r;
  logic [POS_W-1:0]    pos_r;

  // deque state
  logic [AW-1:0] front_r;
  logic [CW-1:0] count_r;
  logic          rev_r;
  logic [CW-1:0] scan_idx_r;

  // result and output registers
  logic [STATUS_W-1:0] res_status_r;
  logic                res_found_r;
  logic [VALUE_W-1:0]  res_rd_r;
  logic [STATUS_W-1:0] o_status_r;
  logic                o_found_r;
  logic [VALUE_W-1:0]  o_rd_r;
  logic [COUNT_W-1:0]  o_count_r;

  logic [EW-1:0] val_elem;
  logic [EW-1:0] rdata;
  logic          full, empty, to_low;
  logic [AW-1:0] front_dec, front_inc;
  logic [XW-1:0] pos_x, cnt_x, get_off_x;
  logic [AW-1:0] wr_off, rd_off;
  logic [AW:0]   wr_sum, rd_sum;
  logic [AW-1:0] wr_slot, rd_slot, waddr;
  logic          we, re, hit, scan_end;
  logic          in_range;

  assign val_elem = EW'(value_r);
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  // low end is physical front; reverse swaps which logical end that is
  assign to_low   = (op_r == OP_ADD_FRONT || op_r == OP_REM_FRONT) != rev_r;

  assign front_dec = (front_r == '0) ? AW'(CAPACITY - 1) : front_r - 1'b1;
  assign front_inc = (front_r == AW'(CAPACITY - 1)) ? '0 : front_r + 1'b1;

  assign pos_x     = XW'(pos_r);
  assign cnt_x     = XW'(count_r);
  assign in_range  = (pos_x < cnt_x);
  assign get_off_x = rev_r ? (cnt_x - 1'b1 - pos_x) : pos_x;

  // physical slot = (front + offset) mod capacity, one compare and subtract
  assign wr_off  = AW'(count_r);
  assign wr_sum  = {1'b0, front_r} + {1'b0, wr_off};
  assign wr_slot = (wr_sum >= (AW+1)'(CAPACITY)) ? AW'(wr_sum - (AW+1)'(CAPACITY))
                                                 : AW'(wr_sum);

  always_comb begin
    if (cmd.scan_step) begin
      rd_off = AW'(scan_idx_r);
    end else if (op_r == OP_GET) begin
      rd_off = AW'(get_off_x);
    end else begin
      rd_off = '0;
    end
  end
  assign rd_sum  = {1'b0, front_r} + {1'b0, rd_off};
  assign rd_slot = (rd_sum >= (AW+1)'(CAPACITY)) ? AW'(rd_sum - (AW+1)'(CAPACITY))
                                                 : AW'(rd_sum);

  assign hit      = (rdata == val_elem);
  assign scan_end = (scan_idx_r == count_r);

  assign we    = cmd.exec && (op_r == OP_ADD_FRONT || op_r == OP_ADD_BACK) && !full;
  assign waddr = to_low ? front_dec : wr_slot;
  assign re    = (cmd.exec && (op_r == OP_GET || op_r == OP_CONTAINS))
              || (cmd.scan_step && !hit && !scan_end);

  assign stat.need_read = (op_r == OP_GET) && in_range;
  assign stat.need_scan = (op_r == OP_CONTAINS) && !empty;
  assign stat.scan_done = hit || scan_end;

  bdq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (val_elem),
    .re    (re),
    .raddr (rd_slot),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (cmd.exec) begin
      case (op_r)
        OP_ADD_FRONT, OP_ADD_BACK: begin
          if (!full) begin
            count_r <= count_r + 1'b1;
            if (to_low) begin
              front_r <= front_dec;
            end
          end
        end
        OP_REM_FRONT, OP_REM_BACK: begin
          if (!empty) begin
            count_r <= count_r - 1'b1;
            if (to_low) begin
              front_r <= front_inc;
            end
          end
        end
        OP_REVERSE: rev_r <= !rev_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_opcode;
      value_r <= in_value;
      pos_r   <= in_position;
    end

    if (cmd.exec) begin
      res_found_r <= 1'b0;
      res_rd_r    <= '0;
      scan_idx_r  <= CW'(1);
      case (op_r)
        OP_ADD_FRONT, OP_ADD_BACK: res_status_r <= full ? ST_FULL : ST_OK;
        OP_REM_FRONT, OP_REM_BACK: res_status_r <= empty ? ST_EMPTY : ST_OK;
        OP_GET:                    res_status_r <= in_range ? ST_OK : ST_RANGE;
        default:                   res_status_r <= ST_OK;
      endcase
    end

    if (cmd.rd_capture) begin
      res_rd_r <= VALUE_W'(rdata);
    end

    // data in hand belongs to entry scan_idx-1; next read is issued ahead
    if (cmd.scan_step) begin
      if (hit) begin
        res_found_r <= 1'b1;
      end else if (!scan_end) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end

    if (cmd.load_out) begin
      o_status_r <= res_status_r;
      o_found_r  <= res_found_r;
      o_rd_r     <= res_rd_r;
      o_count_r  <= COUNT_W'(count_r);
    end
  end

  assign out_status        = o_status_r;
  assign out_found         = o_found_r;
  assign out_read_value    = o_rd_r;
  assign out_element_count = o_count_r;

endmodule

### sv/bounded_deque_with_search_top.sv
// top level of the bounded deque with search
// Bounded deque of up to CAPACITY elements in a ring buffer held in one RAM with a
// registered read port. One request is worked on at a time; the next request is taken
// while the previous result still waits in the output register. Add, remove, reverse
// and the no-op code pass through an execute and a finish state; get adds a read state
// (skipped when the position is out of range), and contains adds a scan state (skipped
// on an empty store) that stops at the first hit, its pace set by the single RAM read
// port that delivers one compare per cycle.
// The element RAM needs no clearing after reset: only data read from live slots ever reaches a result.
module bounded_deque_with_search_top #(
  parameter int CAPACITY      = 256,
  parameter int ELEMENT_WIDTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  bdq_in_if.sink    in_ch,
  bdq_out_if.source out_ch
);
  import bdq_pkg::*;

  bdq_cmd_t  cmd;
  bdq_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdq_dp #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_opcode         (in_ch.opcode),
    .in_value          (in_ch.value),
    .in_position       (in_ch.position),
    .cmd               (cmd),
    .stat              (stat),
    .out_status        (out_ch.status),
    .out_found         (out_ch.found),
    .out_read_value    (out_ch.read_value),
    .out_element_count (out_ch.element_count)
  );

endmodule

### sim/bdq_result_checker.sv
// scoreboard for the bounded deque: predicts every result and checks the result channel
module bdq_result_checker (
  input  logic clk,
  input  logic rst_n,
  bdq_in_if    in_mon,
  bdq_out_if   out_mon,
  output int   mismatch_count,
  output int   results_owed
);
  import bdq_pkg::*;

  localparam int DEPTH = 256;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  element_count;
  } deque_result_t;

  deque_result_t expected_results[$];

  // shadow ring buffer
  logic [VALUE_W-1:0] slots [0:DEPTH-1];
  logic [POS_W-1:0]   head;
  logic [COUNT_W-1:0] fill;
  logic               flipped;

  function automatic deque_result_t deque_apply(input logic [OPCODE_W-1:0] op,
                                                input logic [VALUE_W-1:0]  v,
                                                input logic [POS_W-1:0]    p);
    deque_result_t      r;
    logic [POS_W-1:0]   idx;
    logic [POS_W-1:0]   off;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ADD_FRONT, OP_ADD_BACK: begin
        if (fill == COUNT_W'(DEPTH)) begin
          r.status = ST_FULL;
        end else if ((op == OP_ADD_FRONT) != flipped) begin
          head = head - 1'b1;
          slots[head] = v;
          fill = fill + 1'b1;
        end else begin
          idx = head + fill[POS_W-1:0];
          slots[idx] = v;
          fill = fill + 1'b1;
        end
      end
      OP_REM_FRONT, OP_REM_BACK: begin
        if (fill == '0) begin
          r.status = ST_EMPTY;
        end else begin
          // popping the low end moves the physical front, the high end only shrinks
          if ((op == OP_REM_FRONT) != flipped) head = head + 1'b1;
          fill = fill - 1'b1;
        end
      end
      OP_CONTAINS: begin
        for (int i = 0; i < fill && !r.found; i++) begin
          idx = head + POS_W'(i);
          if (slots[idx] == v) r.found = 1'b1;
        end
      end
      OP_GET: begin
        if ({1'b0, p} >= fill) begin
          r.status = ST_RANGE;
        end else begin
          off = flipped ? POS_W'(fill - 1 - p) : p;
          idx = head + off;
          r.read_value = slots[idx];
        end
      end
      OP_REVERSE: begin
        flipped = !flipped;
      end
      default: begin
      end
    endcase
    r.element_count = fill;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    deque_result_t got;
    deque_result_t want;
    if (!rst_n) begin
      head = '0;
      fill = '0;
      flipped = 1'b0;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      // a result always leaves after its request was taken, so check before predicting
      if (out_mon.valid && out_mon.ready) begin
        got.status        = out_mon.status;
        got.found         = out_mon.found;
        got.read_value    = out_mon.read_value;
        got.element_count = out_mon.element_count;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transaction: status %0d found %0d value %0h count %0d",
                     got.status, got.found, got.read_value, got.element_count);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.read_value !== want.read_value ||
              got.element_count !== want.element_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result mismatch (exp/got): status %0d/%0d found %0d/%0d",
                        " value %0h/%0h count %0d/%0d"},
                       want.status, got.status, want.found, got.found,
                       want.read_value, got.read_value, want.element_count, got.element_count);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(deque_apply(in_mon.opcode, in_mon.value, in_mon.position));
    end
    results_owed = expected_results.size();
  end

endmodule

### sim/bounded_deque_with_search_top_tb.sv
// testbench top: drives deque operations against the block and gives the verdict
module bounded_deque_with_search_top_tb;
  import bdq_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

  typedef enum logic [1:0] {LEAN_FILL, LEAN_DRAIN, LEAN_MIXED} op_lean_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   mismatch_count;
  int   results_owed;
  logic signed [VALUE_W-1:0] recent_values[$];

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  bounded_deque_with_search_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bdq_result_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #10000000;
    $display("bounded_deque_with_search_top_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [OPCODE_W-1:0] pick_add();
    return $urandom_range(1) ? OP_ADD_FRONT : OP_ADD_BACK;
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_remove();
    return $urandom_range(1) ? OP_REM_FRONT : OP_REM_BACK;
  endfunction

  // one request transaction, with random idle cycles in front of it
  task automatic issue(input logic [OPCODE_W-1:0] op, input logic signed [VALUE_W-1:0] v,
                       input logic [POS_W-1:0] p);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.value    <= v;
    in_ch.position <= p;
    if (op == OP_ADD_FRONT || op == OP_ADD_BACK) begin
      recent_values.push_back(v);
      if (recent_values.size() > 32) void'(recent_values.pop_front());
    end
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold off until every result is back, then switch the idling mix
  task automatic set_pace(input int idle_pct, input int stall_pct);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    @(posedge clk);
  endtask

  task automatic random_item(input op_lean_t lean);
    int                        roll;
    logic [OPCODE_W-1:0]       op;
    logic signed [VALUE_W-1:0] v;
    logic [POS_W-1:0]          p;
    roll = $urandom_range(99);
    if (lean == LEAN_FILL) begin
      if (roll < 70)      op = pick_add();
      else if (roll < 80) op = OP_CONTAINS;
      else if (roll < 88) op = OP_GET;
      else if (roll < 93) op = pick_remove();
      else if (roll < 97) op = OP_REVERSE;
      else                op = OP_UNUSED;
    end else if (lean == LEAN_DRAIN) begin
      if (roll < 80)      op = pick_remove();
      else if (roll < 85) op = pick_add();
      else if (roll < 91) op = OP_CONTAINS;
      else if (roll < 96) op = OP_GET;
      else if (roll < 98) op = OP_REVERSE;
      else                op = OP_UNUSED;
    end else begin
      if (roll < 25)      op = pick_add();
      else if (roll < 50) op = pick_remove();
      else if (roll < 65) op = OP_CONTAINS;
      else if (roll < 85) op = OP_GET;
      else if (roll < 95) op = OP_REVERSE;
      else                op = OP_UNUSED;
    end
    // small values and repeats of recent adds make searches hit
    case ($urandom_range(3))
      0: v = $urandom_range(15);
      1: v = (recent_values.size() != 0) ?
             recent_values[$urandom_range(recent_values.size() - 1)] : '0;
      default: v = $urandom;
    endcase
    p = $urandom_range(1) ? POS_W'($urandom_range(255)) : POS_W'($urandom_range(15));
    issue(op, v, p);
  endtask

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_ADD_FRONT;
    in_ch.value    <= '0;
    in_ch.position <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store corner cases
    issue(OP_GET, '0, '0);
    issue(OP_REM_FRONT, '0, '0);
    issue(OP_REM_BACK, '0, '0);
    issue(OP_CONTAINS, '0, '0);
    issue(OP_REVERSE, '0, '0);
    issue(OP_UNUSED, $urandom, POS_W'($urandom_range(255)));
    issue(OP_REVERSE, '0, '0);
    // extremes of the value field
    issue(OP_ADD_FRONT, 32'h7fffffff, '0);
    issue(OP_ADD_BACK, 32'h80000000, '0);
    issue(OP_ADD_FRONT, '0, '0);
    issue(OP_ADD_BACK, '1, '0);
    issue(OP_GET, '0, 8'd0);
    issue(OP_GET, '0, 8'd3);
    issue(OP_GET, '0, 8'd4);
    issue(OP_GET, '0, 8'hff);
    issue(OP_CONTAINS, '1, '0);
    issue(OP_CONTAINS, 32'h80000000, '0);
    issue(OP_CONTAINS, 32'd12345, '0);
    // reversed order: front and back swap ends
    issue(OP_REVERSE, '0, '0);
    issue(OP_GET, '0, 8'd0);
    issue(OP_ADD_FRONT, 32'd5, '0);
    issue(OP_GET, '0, 8'd0);
    issue(OP_REM_BACK, '0, '0);
    issue(OP_REM_FRONT, '0, '0);
    issue(OP_UNUSED, '1, '1);

    set_pace(0, 0);
    repeat (400) random_item(LEAN_FILL);
    set_pace(83, 0);
    repeat (100) random_item(LEAN_MIXED);
    set_pace(0, 83);
    repeat (380) random_item(LEAN_DRAIN);
    set_pace(18, 18);
    repeat (150) random_item(LEAN_MIXED);
    set_pace(0, 0);

    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("bounded_deque_with_search_top_tb: clean");
    end else begin
      $display("bounded_deque_with_search_top_tb: errors");
    end
    $finish;
  end

endmodule
